// ===== design/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants, register indexes and saturation helper for the
// ray/triangle intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIST_W  = 31;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic coord_t sat32(input logic signed [63:0] x);
    coord_t r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = coord_t'(x);
    end
    return r;
  endfunction

endpackage

// ===== design/ray_triangle_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Pipelined Moller-Trumbore ray/triangle test in signed fixed point.
// ----------------------------------------------------------------------------
// One triangle request is taken in every cycle that the output side is not
// stalled. Each request passes through six stages for the origin offset, the
// cross and dot products and the sign fix, one setup stage and 31 stages of
// the restoring dividers (one quotient bit per stage, three lanes for t, u and
// v), and the output register. A stall on the result side holds the whole
// pipeline. The user must write the static ray origin and direction registers
// through the configuration port only while no request is in flight; unenforced.
module ray_triangle_intersect_unit
  import rti_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  input  logic                 tri_valid,
  output logic                 tri_stall,
  input  logic signed [31:0]   base_x,
  input  logic signed [31:0]   base_y,
  input  logic signed [31:0]   base_z,
  input  logic signed [31:0]   edge1_x,
  input  logic signed [31:0]   edge1_y,
  input  logic signed [31:0]   edge1_z,
  input  logic signed [31:0]   edge2_x,
  input  logic signed [31:0]   edge2_y,
  input  logic signed [31:0]   edge2_z,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 hit,
  output logic [DIST_W-1:0]    distance,
  output logic [WGT_W-1:0]     weight_w,
  output logic [WGT_W-1:0]     weight_u,
  output logic [WGT_W-1:0]     weight_v
);

  // Dot products of shifted products need this many signed bits.
  localparam int unsigned DW   = 66 - FRAC_BITS;
  // Divider remainder width: holds the divisor shifted by up to 31.
  localparam int unsigned WW   = DW + 31;
  localparam int unsigned NDIV = 31;

  function automatic logic signed [63:0] fmul(input coord_t a, input coord_t b);
    logic signed [63:0] m;
    m = 64'(a) * 64'(b);
    return m >>> FRAC_BITS;
  endfunction

  coord_t origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      dir_x    <= '0;
      dir_y    <= '0;
      dir_z    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_ORIGIN_Z: origin_z <= cfg_data;
        REG_DIR_X:    dir_x    <= cfg_data;
        REG_DIR_Y:    dir_y    <= cfg_data;
        REG_DIR_Z:    dir_z    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign tri_stall = !adv;

  // Stage 1: origin minus base vertex.
  logic   v1;
  coord_t s1 [3];
  coord_t e1a [3];
  coord_t e2a [3];

  // Stage 2: cross product terms.
  logic               v2;
  logic signed [63:0] pp [12];
  coord_t             s2 [3];
  coord_t             e1b [3];
  coord_t             e2b [3];

  // Stage 3: cross products p = d x e2, q = s x e1.
  logic   v3;
  coord_t p3 [3];
  coord_t q3 [3];
  coord_t s3 [3];
  coord_t e1c [3];
  coord_t e2c [3];

  // Stage 4: dot product terms.
  logic               v4;
  logic signed [63:0] dp [12];

  // Stage 5: det and numerators.
  logic                 v5;
  logic signed [DW-1:0] det5, un5, vn5, tn5;

  // Stage 6: sign fix and early miss decision.
  logic          v6, miss6;
  logic [DW-1:0] det6, un6, vn6, tn6;

  logic signed [DW-1:0] det_f, un_f, vn_f, tn_f;
  logic signed [DW:0]   uv_sum;

  always_comb begin
    if (det5 < 0) begin
      det_f = -det5;
      un_f  = -un5;
      vn_f  = -vn5;
      tn_f  = -tn5;
    end else begin
      det_f = det5;
      un_f  = un5;
      vn_f  = vn5;
      tn_f  = tn5;
    end
    uv_sum = (DW+1)'(un_f) + (DW+1)'(vn_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= tri_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1[0]  <= sat32(64'(origin_x) - 64'(base_x));
      s1[1]  <= sat32(64'(origin_y) - 64'(base_y));
      s1[2]  <= sat32(64'(origin_z) - 64'(base_z));
      e1a[0] <= edge1_x;
      e1a[1] <= edge1_y;
      e1a[2] <= edge1_z;
      e2a[0] <= edge2_x;
      e2a[1] <= edge2_y;
      e2a[2] <= edge2_z;

      pp[0]  <= fmul(dir_y, e2a[2]);
      pp[1]  <= fmul(dir_z, e2a[1]);
      pp[2]  <= fmul(dir_z, e2a[0]);
      pp[3]  <= fmul(dir_x, e2a[2]);
      pp[4]  <= fmul(dir_x, e2a[1]);
      pp[5]  <= fmul(dir_y, e2a[0]);
      pp[6]  <= fmul(s1[1], e1a[2]);
      pp[7]  <= fmul(s1[2], e1a[1]);
      pp[8]  <= fmul(s1[2], e1a[0]);
      pp[9]  <= fmul(s1[0], e1a[2]);
      pp[10] <= fmul(s1[0], e1a[1]);
      pp[11] <= fmul(s1[1], e1a[0]);
      s2     <= s1;
      e1b    <= e1a;
      e2b    <= e2a;

      p3[0] <= sat32(pp[0] - pp[1]);
      p3[1] <= sat32(pp[2] - pp[3]);
      p3[2] <= sat32(pp[4] - pp[5]);
      q3[0] <= sat32(pp[6] - pp[7]);
      q3[1] <= sat32(pp[8] - pp[9]);
      q3[2] <= sat32(pp[10] - pp[11]);
      s3    <= s2;
      e1c   <= e1b;
      e2c   <= e2b;

      dp[0]  <= fmul(e1c[0], p3[0]);
      dp[1]  <= fmul(e1c[1], p3[1]);
      dp[2]  <= fmul(e1c[2], p3[2]);
      dp[3]  <= fmul(s3[0], p3[0]);
      dp[4]  <= fmul(s3[1], p3[1]);
      dp[5]  <= fmul(s3[2], p3[2]);
      dp[6]  <= fmul(dir_x, q3[0]);
      dp[7]  <= fmul(dir_y, q3[1]);
      dp[8]  <= fmul(dir_z, q3[2]);
      dp[9]  <= fmul(e2c[0], q3[0]);
      dp[10] <= fmul(e2c[1], q3[1]);
      dp[11] <= fmul(e2c[2], q3[2]);

      det5 <= DW'(dp[0]) + DW'(dp[1]) + DW'(dp[2]);
      un5  <= DW'(dp[3]) + DW'(dp[4]) + DW'(dp[5]);
      vn5  <= DW'(dp[6]) + DW'(dp[7]) + DW'(dp[8]);
      tn5  <= DW'(dp[9]) + DW'(dp[10]) + DW'(dp[11]);

      det6  <= det_f;
      un6   <= un_f;
      vn6   <= vn_f;
      tn6   <= tn_f;
      miss6 <= (det_f == 0) || (un_f < 0) || (un_f > det_f) || (vn_f < 0) ||
               (uv_sum > (DW+1)'(det_f)) || (tn_f <= 0);
    end
  end

  // Divider pipeline. Index 0 is the setup stage; stage j resolves quotient
  // bit NDIV-j. Lane 0 is t, lane 1 is u, lane 2 is v.
  logic              dv   [NDIV+1];
  logic              dmis [NDIV+1];
  logic [DW-1:0]     dden [NDIV+1];
  logic [WW-1:0]     drem [3][NDIV+1];
  logic [DIST_W-1:0] dquo [3][NDIV+1];
  logic              dovf [3][NDIV+1];

  logic [DW-1:0] num6 [3];
  assign num6[0] = tn6;
  assign num6[1] = un6;
  assign num6[2] = vn6;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmis[0] <= miss6;
      dden[0] <= det6;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_setup
    always_ff @(posedge clk) begin
      if (adv) begin
        // A quotient of 2^31 or more saturates.
        dovf[l][0] <= WW'(num6[l]) >= (WW'(det6) << (31 - FRAC_BITS));
        drem[l][0] <= WW'(num6[l]) << FRAC_BITS;
        dquo[l][0] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    localparam int unsigned B = NDIV - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (adv) begin
        dv[j] <= dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dmis[j] <= dmis[j-1];
        dden[j] <= dden[j-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [WW-1:0] sub;
      assign sub = WW'(dden[j-1]) << B;

      always_ff @(posedge clk) begin
        if (adv) begin
          dovf[l][j] <= dovf[l][j-1];
          if (drem[l][j-1] >= sub) begin
            drem[l][j] <= drem[l][j-1] - sub;
            dquo[l][j] <= dquo[l][j-1] | (DIST_W'(1) << B);
          end else begin
            drem[l][j] <= drem[l][j-1];
            dquo[l][j] <= dquo[l][j-1];
          end
        end
      end
    end
  end

  logic [DIST_W-1:0] t_q, u_q, v_q;
  logic              hit_c;
  logic [31:0]       w_c;

  always_comb begin
    t_q   = dovf[0][NDIV] ? DIST_MAX : dquo[0][NDIV];
    u_q   = dovf[1][NDIV] ? DIST_MAX : dquo[1][NDIV];
    v_q   = dovf[2][NDIV] ? DIST_MAX : dquo[2][NDIV];
    hit_c = !dmis[NDIV] && (t_q != 0);
    w_c   = (32'd1 << FRAC_BITS) - 32'(u_q) - 32'(v_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= hit_c;
      if (hit_c) begin
        distance <= t_q;
        weight_w <= w_c[WGT_W-1:0];
        weight_u <= u_q[WGT_W-1:0];
        weight_v <= v_q[WGT_W-1:0];
      end else begin
        distance <= DIST_MAX;
        weight_w <= '0;
        weight_u <= '0;
        weight_v <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    (res_valid && hit) |-> (distance != 0))
    else $error("hit with zero distance");

  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !hit) |-> (distance == DIST_MAX && weight_w == 0 &&
                              weight_u == 0 && weight_v == 0))
    else $error("miss result carries data");

  a_weight_sum: assert property (@(posedge clk) disable iff (rst)
    (res_valid && hit && FRAC_BITS <= 16) |->
      (32'(weight_w) + 32'(weight_u) + 32'(weight_v) == (32'd1 << FRAC_BITS)))
    else $error("barycentric weights do not sum to one");
`endif

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Ray/triangle intersection unit testbench
// Streams triangle requests against several ray settings and checks every
// result against a fixed-point Moller-Trumbore predictor. Both handshake
// sides idle at random. One long result hold backs up the pipeline.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 45;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    coord_t bx, by, bz, ax, ay, az, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic [WGT_W-1:0]  w, u, v;
  } isect_t;

  class intersect_scoreboard;
    longint ray[6];
    isect_t pending[$];
    int     errors;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
      if (idx <= REG_DIR_Z) ray[idx] = longint'(val);
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint fmul(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function void cross3(input longint a[3], input longint b[3], output longint r[3]);
      r[0] = clamp32(fmul(a[1], b[2]) - fmul(a[2], b[1]));
      r[1] = clamp32(fmul(a[2], b[0]) - fmul(a[0], b[2]));
      r[2] = clamp32(fmul(a[0], b[1]) - fmul(a[1], b[0]));
    endfunction

    function longint dot3(input longint a[3], input longint b[3]);
      return fmul(a[0], b[0]) + fmul(a[1], b[1]) + fmul(a[2], b[2]);
    endfunction

    // Fixed-point quotient n/d, one fraction bit per step, saturated.
    function longint quot(longint n, longint d);
      longint q, r;
      q = n / d;
      r = n % d;
      if (q > (64'sh7FFFFFFF >>> FRAC)) return 64'sh7FFFFFFF;
      for (int i = 0; i < FRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      return q;
    endfunction

    function void note(tri_t t);
      longint dv[3], sv[3], e1[3], e2[3], p[3], q[3];
      longint det, un, vn, tn, tq, uq, vq;
      isect_t e;
      dv = '{ray[REG_DIR_X], ray[REG_DIR_Y], ray[REG_DIR_Z]};
      sv[0] = clamp32(ray[REG_ORIGIN_X] - longint'(t.bx));
      sv[1] = clamp32(ray[REG_ORIGIN_Y] - longint'(t.by));
      sv[2] = clamp32(ray[REG_ORIGIN_Z] - longint'(t.bz));
      e1 = '{longint'(t.ax), longint'(t.ay), longint'(t.az)};
      e2 = '{longint'(t.cx), longint'(t.cy), longint'(t.cz)};
      cross3(dv, e2, p);
      cross3(sv, e1, q);
      det = dot3(e1, p);
      un = dot3(sv, p);
      vn = dot3(dv, q);
      tn = dot3(e2, q);
      if (det < 0) begin
        det = -det;
        un = -un;
        vn = -vn;
        tn = -tn;
      end
      e = '{hit: 1'b0, distance: DIST_MAX, default: '0};
      if (!(det == 0 || un < 0 || un > det || vn < 0 || un + vn > det || tn <= 0)) begin
        tq = quot(tn, det);
        if (tq != 0) begin
          uq = quot(un, det);
          vq = quot(vn, det);
          e.hit = 1'b1;
          e.distance = tq[DIST_W-1:0];
          e.w = WGT_W'(ONE - uq - vq);
          e.u = uq[WGT_W-1:0];
          e.v = vq[WGT_W-1:0];
        end
      end
      pending = {pending, e};
    endfunction

    function void report(string name, longint ex, longint ac);
      if (ex != ac) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, ex, ac);
        errors++;
      end
    endfunction

    function void check(isect_t r);
      isect_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0h", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      report("hit", e.hit, r.hit);
      report("distance", e.distance, r.distance);
      report("weight_w", e.w, r.w);
      report("weight_u", e.u, r.u);
      report("weight_v", e.v, r.v);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;
  logic tri_valid = 1'b0;
  logic tri_stall;
  tri_t cur = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  isect_t res;

  int stall_pct = 0;
  int gap_pct = 0;
  bit hold_req = 1'b0;
  int cycles = 0;
  intersect_scoreboard sb = new();

  ray_triangle_intersect_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .tri_valid(tri_valid), .tri_stall(tri_stall),
    .base_x(cur.bx), .base_y(cur.by), .base_z(cur.bz),
    .edge1_x(cur.ax), .edge1_y(cur.ay), .edge1_z(cur.az),
    .edge2_x(cur.cx), .edge2_y(cur.cy), .edge2_z(cur.cz),
    .res_valid(res_valid), .res_stall(res_stall),
    .hit(res.hit), .distance(res.distance),
    .weight_w(res.w), .weight_u(res.u), .weight_v(res.v)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: checks accepted results and picks the next stall.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check(res);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end else if (hold_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < 3) begin
        hold_left = $urandom_range(10, 40);
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_tri(tri_t t);
    int r, gap;
    tri_valid <= 1'b1;
    cur <= t;
    do @(posedge clk); while (tri_stall);
    sb.note(t);
    r = $urandom_range(0, 99);
    gap = 0;
    if (r < gap_pct) gap = (r < gap_pct / 8) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      tri_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every result is back and the pipeline has emptied.
  task automatic settle();
    tri_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz);
    write_reg(REG_ORIGIN_X, coord_t'(ox));
    write_reg(REG_ORIGIN_Y, coord_t'(oy));
    write_reg(REG_ORIGIN_Z, coord_t'(oz));
    write_reg(REG_DIR_X, coord_t'(dx));
    write_reg(REG_DIR_Y, coord_t'(dy));
    write_reg(REG_DIR_Z, coord_t'(dz));
    // Indexes past the last register must leave the ray alone.
    write_reg(REG_SPARE_A, coord_t'($urandom));
    write_reg(REG_SPARE_B, coord_t'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tri_t noise_tri();
    tri_t t;
    t = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    return t;
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Builds a triangle around a point on the ray, so most requests hit.
  function automatic tri_t aimed_tri();
    tri_t t;
    longint e1[3], e2[3], pt[3], a, b, k;
    k = $urandom_range(1, 20);
    a = $urandom_range(0, 45000);
    b = $urandom_range(0, 45000);
    for (int i = 0; i < 3; i++) begin
      e1[i] = spread(8 * ONE);
      e2[i] = spread(8 * ONE);
      pt[i] = sb.ray[i] + k * sb.ray[REG_DIR_X + i]
              - ((e1[i] * a) >>> FRAC) - ((e2[i] * b) >>> FRAC);
    end
    t = {coord_t'(pt[0]), coord_t'(pt[1]), coord_t'(pt[2]),
         coord_t'(e1[0]), coord_t'(e1[1]), coord_t'(e1[2]),
         coord_t'(e2[0]), coord_t'(e2[1]), coord_t'(e2[2])};
    return t;
  endfunction

  function automatic tri_t flat_tri(longint px, longint py, longint pz);
    tri_t t;
    t = {coord_t'(px), coord_t'(py), coord_t'(pz),
         coord_t'(4 * ONE), 32'sd0, 32'sd0, 32'sd0, coord_t'(4 * ONE), 32'sd0};
    return t;
  endfunction

  initial begin
    tri_t t;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset ray has zero direction, so every request is a miss.
    repeat (3) send_tri(noise_tri());
    send_tri(flat_tri(-ONE, -ONE, 5 * ONE));
    settle();

    set_ray(0, 0, 0, 0, 0, ONE);
    send_tri(flat_tri(-ONE, -ONE, 5 * ONE));
    t = flat_tri(-ONE, -ONE, 5 * ONE);
    {t.ax, t.ay, t.az, t.cx, t.cy, t.cz} = {t.cx, t.cy, t.cz, t.ax, t.ay, t.az};
    send_tri(t);                                  // negative determinant
    send_tri(flat_tri(ONE, -ONE, 5 * ONE));       // u below zero
    send_tri(flat_tri(-5 * ONE, -ONE, 5 * ONE));  // u above one
    send_tri(flat_tri(-ONE, ONE, 5 * ONE));       // v below zero
    send_tri(flat_tri(-3 * ONE, -3 * ONE, 5 * ONE));
    send_tri(flat_tri(-ONE, -ONE, -5 * ONE));     // behind the origin
    send_tri(flat_tri(-ONE, -ONE, 0));            // at the origin
    send_tri(flat_tri(-4 * ONE, 0, 5 * ONE));     // exactly on a vertex
    send_tri(flat_tri(0, 0, 5 * ONE));
    t = flat_tri(-ONE, -ONE, 5 * ONE);
    t.cx = 0;
    t.cy = 0;
    t.cz = coord_t'(ONE);
    send_tri(t);                                  // edge parallel to the ray
    send_tri({9{32'sh7FFFFFFF}});
    send_tri({9{32'sh80000000}});
    send_tri('0);
    send_tri({9{32'sh55555555}});
    send_tri({9{32'shAAAAAAAA}});
    settle();

    // Steep direction makes t round to zero; tiny direction saturates t.
    set_ray(0, 0, 0, 0, 0, 100 * ONE);
    send_tri(flat_tri(-ONE, -ONE, 1));
    send_tri(flat_tri(-ONE, -ONE, 3 * ONE));
    settle();
    set_ray(0, 0, 0, 0, 0, 1);
    send_tri(flat_tri(-ONE, -ONE, 30000 * ONE));
    send_tri(flat_tri(-ONE, -ONE, 2));
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) set_ray(64'sh7FFFFFFF, 64'sh7FFFFFFF, -64'sh80000000,
                           -64'sh80000000, 64'sh7FFFFFFF, -64'sh80000000);
      else set_ray(spread(100 * ONE), spread(100 * ONE), spread(100 * ONE),
                   spread(4 * ONE), spread(4 * ONE), spread(4 * ONE));
      stall_pct = (ph % 4 == 0) ? 0 : 15 * (ph % 4);
      gap_pct = (ph % 3 == 0) ? 0 : 20 * (ph % 3);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 99) < 80) send_tri(aimed_tri());
        else send_tri(noise_tri());
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
